// ----- hdl/hbs_pkg.sv -----
// Shared types and constants of the heightmap bilinear sampler.
// No dependencies; every other file but hbs_queue refers to this package by scoped names.
`timescale 1ns / 1ps

package hbs_pkg;

   localparam int ADDR_W      = 16;
   localparam int STORE_DEPTH = 2 ** ADDR_W;
   localparam int POS_W       = 16;
   localparam int HEIGHT_W    = 8;
   localparam int DIM_W       = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int REQ_DATA_W  = ADDR_W + HEIGHT_W + 2 * POS_W;

   // Largest usable map size; larger register writes are clamped to these.
   localparam logic [DIM_W-1:0] MAX_WIDTH = 9'd256;
   localparam logic [DIM_W-1:0] MAX_ROWS  = 9'd256;
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 4'd1;

   // What the back end has to do with one item.
   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_ZERO,
      KIND_CELL,
      KIND_BLEND
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [ADDR_W-1:0]           addr;
      logic signed [HEIGHT_W-1:0]  wdata;
   } entry_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } map_dims_type;

endpackage

// ----- hdl/hbs_front.sv -----
// Front end of the heightmap bilinear sampler: accepts items and classifies them.
// Depends on hbs_pkg; feeds the command queue in front of hbs_back.
`timescale 1ns / 1ps

module hbs_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_cmd,
   input  logic [hbs_pkg::ADDR_W-1:0]         in_cell_index,
   input  logic signed [hbs_pkg::HEIGHT_W-1:0] in_cell_height,
   input  logic [hbs_pkg::POS_W-1:0]          in_pos_x,
   input  logic [hbs_pkg::POS_W-1:0]          in_pos_y,
   input  hbs_pkg::map_dims_type              dims,
   output logic                               out_valid,
   input  logic                               out_ready,
   output hbs_pkg::entry_type                 out_entry,
   output logic [FRAC_BITS-1:0]               out_fx,
   output logic [FRAC_BITS-1:0]               out_fy
);

   localparam int POS_W  = hbs_pkg::POS_W;
   localparam int DIM_W  = hbs_pkg::DIM_W;
   localparam int ADDR_W = hbs_pkg::ADDR_W;

   logic [POS_W-1:0]       xi;
   logic [POS_W-1:0]       yi;
   logic [FRAC_BITS-1:0]   fx;
   logic [FRAC_BITS-1:0]   fy;
   logic [POS_W-1:0]       width_ext;
   logic [POS_W-1:0]       height_ext;
   logic [POS_W:0]         xi_next;
   logic [POS_W:0]         yi_next;
   logic                   outside;
   logic                   at_border;
   logic [2*DIM_W-1:0]     row_offset;
   logic [2*DIM_W-1:0]     base_sum;
   hbs_pkg::entry_type     entry;

   logic                   valid_ff;
   logic                   valid_in;
   hbs_pkg::entry_type     entry_ff;
   logic [FRAC_BITS-1:0]   fx_ff;
   logic [FRAC_BITS-1:0]   fy_ff;
   logic                   accept;

   assign xi         = in_pos_x >> FRAC_BITS;
   assign yi         = in_pos_y >> FRAC_BITS;
   assign fx         = in_pos_x[FRAC_BITS-1:0];
   assign fy         = in_pos_y[FRAC_BITS-1:0];
   assign width_ext  = {{(POS_W-DIM_W){1'b0}}, dims.width};
   assign height_ext = {{(POS_W-DIM_W){1'b0}}, dims.height};
   assign xi_next    = {1'b0, xi} + {{POS_W{1'b0}}, 1'b1};
   assign yi_next    = {1'b0, yi} + {{POS_W{1'b0}}, 1'b1};
   assign outside    = (xi >= width_ext) || (yi >= height_ext);
   assign at_border  = (xi_next >= {1'b0, width_ext}) || (yi_next >= {1'b0, height_ext});

   // Inside the map the integer coordinates fit the register width.
   assign row_offset = yi[DIM_W-1:0] * dims.width;
   assign base_sum   = row_offset + {{DIM_W{1'b0}}, xi[DIM_W-1:0]};

   always_comb begin
      entry.addr  = base_sum[ADDR_W-1:0];
      entry.wdata = in_cell_height;
      if (!in_cmd) begin
         entry.kind = hbs_pkg::KIND_WRITE;
         entry.addr = in_cell_index;
      end else if (outside) begin
         entry.kind = hbs_pkg::KIND_ZERO;
      end else if ((fx == '0) && (fy == '0)) begin
         entry.kind = hbs_pkg::KIND_CELL;
      end else if (at_border) begin
         entry.kind = hbs_pkg::KIND_ZERO;
      end else begin
         entry.kind = hbs_pkg::KIND_BLEND;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign valid_in  = accept || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry;
         fx_ff    <= fx;
         fy_ff    <= fy;
      end
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;
   assign out_fx    = fx_ff;
   assign out_fy    = fy_ff;

endmodule

// ----- hdl/hbs_queue.sv -----
// Small first-in first-out queue built from registers.
// No package dependency; used between front and back and for the result buffer.
`timescale 1ns / 1ps

module hbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/hbs_back.sv -----
// Back end of the heightmap bilinear sampler: height memory, read sequencer,
// interpolation pipeline and result buffer. Depends on hbs_pkg and hbs_queue.
`timescale 1ns / 1ps

module hbs_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                entry_valid,
   output logic                                entry_ready,
   input  hbs_pkg::entry_type                  entry,
   input  logic [FRAC_BITS-1:0]                entry_fx,
   input  logic [FRAC_BITS-1:0]                entry_fy,
   input  logic [hbs_pkg::DIM_W-1:0]           map_width,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hbs_pkg::HEIGHT_W-1:0]        rsp_data
);

   localparam int ADDR_W    = hbs_pkg::ADDR_W;
   localparam int HEIGHT_W  = hbs_pkg::HEIGHT_W;
   localparam int DIM_W     = hbs_pkg::DIM_W;
   localparam int LERP_W    = HEIGHT_W + FRAC_BITS;
   localparam int LP_W      = HEIGHT_W + FRAC_BITS + 2;
   localparam int T_W       = HEIGHT_W + 2 * FRAC_BITS;
   localparam int TP_W      = HEIGHT_W + 2 * FRAC_BITS + 2;
   localparam int OUT_DEPTH = 4;
   localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
   localparam logic [1:0]          STEP_LAST   = 2'd3;
   localparam logic [CREDIT_W-1:0] CREDIT_FULL = CREDIT_W'(OUT_DEPTH);
   localparam logic [T_W-1:0]      ROUND_BIAS  =
      {{HEIGHT_W{1'b0}}, {(2 * FRAC_BITS){1'b1}}};

   // Sequencer
   logic                        busy_ff;
   logic [1:0]                  step_ff;
   logic [ADDR_W-1:0]           cur_addr_ff;
   logic [FRAC_BITS-1:0]        cur_fx_ff;
   logic [FRAC_BITS-1:0]        cur_fy_ff;
   logic                        op_valid;
   hbs_pkg::kind_type           op_kind;
   logic [1:0]                  op_step;
   logic [ADDR_W-1:0]           op_base;
   logic [FRAC_BITS-1:0]        op_fx;
   logic [FRAC_BITS-1:0]        op_fy;
   logic                        op_final;
   logic                        credit_ok;
   logic                        issue;
   logic [ADDR_W-1:0]           width_addr;
   logic [ADDR_W-1:0]           row_step;
   logic [ADDR_W-1:0]           col_step;
   logic [ADDR_W-1:0]           mem_addr;
   logic [CREDIT_W-1:0]         credit_ff;
   logic [CREDIT_W-1:0]         credit_in;
   logic                        reserve;
   logic                        release_slot;

   // Memory
   logic [HEIGHT_W-1:0]         height_mem [hbs_pkg::STORE_DEPTH];
   logic [HEIGHT_W-1:0]         rdata_ff;

   // Read return stage
   logic                        rd_valid_ff;
   hbs_pkg::kind_type           rd_kind_ff;
   logic [1:0]                  rd_step_ff;
   logic [FRAC_BITS-1:0]        rd_fx_ff;
   logic [FRAC_BITS-1:0]        rd_fy_ff;
   logic signed [HEIGHT_W-1:0]  h_cur;
   logic signed [HEIGHT_W-1:0]  h_first_ff;
   logic signed [HEIGHT_W:0]    h_diff;
   logic signed [FRAC_BITS:0]   fy_s;
   logic signed [LP_W-1:0]      lerp_prod;
   logic signed [LP_W-1:0]      lerp_base;
   logic signed [LP_W-1:0]      lerp_full;
   logic signed [LERP_W-1:0]    a_ff;
   logic                        rd_done;

   // Blend across stage
   logic                        p2_valid_ff;
   logic                        p2_blend_ff;
   logic [FRAC_BITS-1:0]        p2_fx_ff;
   logic signed [LERP_W-1:0]    b_ff;
   logic [HEIGHT_W-1:0]         p2_value_ff;
   logic signed [LERP_W:0]      ab_diff;
   logic signed [FRAC_BITS:0]   fx_s;
   logic signed [TP_W-1:0]      t_prod;
   logic signed [TP_W-1:0]      t_base;
   logic signed [TP_W-1:0]      t_full;

   // Truncation stage
   logic                        p3_valid_ff;
   logic                        p3_blend_ff;
   logic [T_W-1:0]              t_ff;
   logic [HEIGHT_W-1:0]         p3_value_ff;
   logic [T_W-1:0]              t_round;
   logic [HEIGHT_W-1:0]         result;

   // ---------------------------------------------------------------- sequencer
   assign op_valid = busy_ff || entry_valid;
   assign op_kind  = busy_ff ? hbs_pkg::KIND_BLEND : entry.kind;
   assign op_step  = busy_ff ? step_ff : 2'd0;
   assign op_base  = busy_ff ? cur_addr_ff : entry.addr;
   assign op_fx    = busy_ff ? cur_fx_ff : entry_fx;
   assign op_fy    = busy_ff ? cur_fy_ff : entry_fy;

   always_comb begin
      case (op_kind)
         hbs_pkg::KIND_WRITE: op_final = 1'b0;
         hbs_pkg::KIND_BLEND: op_final = (op_step == STEP_LAST);
         default:             op_final = 1'b1;
      endcase
   end

   // A result slot is reserved when its last read is issued, so the
   // pipeline behind the memory never has to stall. A slot that the result
   // stream frees in the same cycle may be taken again at once.
   assign credit_ok   = (credit_ff != CREDIT_FULL) || release_slot;
   assign issue       = op_valid && (!op_final || credit_ok);
   assign entry_ready = !busy_ff && (!op_final || credit_ok);

   // Step bit 0 selects the lower row, step bit 1 the right column.
   assign width_addr = {{(ADDR_W-DIM_W){1'b0}}, map_width};
   assign row_step   = op_step[0] ? width_addr : '0;
   assign col_step   = {{(ADDR_W-1){1'b0}}, op_step[1]};
   assign mem_addr   = op_base + row_step + col_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else if (issue) begin
         if (busy_ff) begin
            busy_ff <= (step_ff != STEP_LAST);
            step_ff <= step_ff + 2'd1;
         end else if (op_kind == hbs_pkg::KIND_BLEND) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue && !busy_ff) begin
         cur_addr_ff <= entry.addr;
         cur_fx_ff   <= entry_fx;
         cur_fy_ff   <= entry_fy;
      end
   end

   assign reserve      = issue && op_final;
   assign release_slot = rsp_valid && rsp_ready;

   always_comb begin
      case ({reserve, release_slot})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (issue && (op_kind == hbs_pkg::KIND_WRITE)) begin
         height_mem[mem_addr] <= entry.wdata;
      end
      rdata_ff <= height_mem[mem_addr];
   end

   // -------------------------------------------------------- read return stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue && (op_kind != hbs_pkg::KIND_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      rd_kind_ff <= op_kind;
      rd_step_ff <= op_step;
      rd_fx_ff   <= op_fx;
      rd_fy_ff   <= op_fy;
   end

   // One lerp unit serves both the left and the right column pair.
   assign h_cur     = $signed(rdata_ff);
   assign h_diff    = {h_cur[HEIGHT_W-1], h_cur} - {h_first_ff[HEIGHT_W-1], h_first_ff};
   assign fy_s      = $signed({1'b0, rd_fy_ff});
   assign lerp_prod = h_diff * fy_s;
   assign lerp_base = {{2{h_first_ff[HEIGHT_W-1]}}, h_first_ff, {FRAC_BITS{1'b0}}};
   assign lerp_full = lerp_base + lerp_prod;

   assign rd_done = rd_valid_ff &&
                    ((rd_kind_ff != hbs_pkg::KIND_BLEND) || (rd_step_ff == STEP_LAST));

   always_ff @(posedge clock) begin
      if (rd_valid_ff && (rd_kind_ff == hbs_pkg::KIND_BLEND)) begin
         if (!rd_step_ff[0]) begin
            h_first_ff <= h_cur;
         end
         if (rd_step_ff == 2'd1) begin
            a_ff <= lerp_full[LERP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= rd_done;
      end
   end

   always_ff @(posedge clock) begin
      p2_blend_ff <= (rd_kind_ff == hbs_pkg::KIND_BLEND);
      p2_fx_ff    <= rd_fx_ff;
      b_ff        <= lerp_full[LERP_W-1:0];
      p2_value_ff <= (rd_kind_ff == hbs_pkg::KIND_CELL) ? rdata_ff : '0;
   end

   // ------------------------------------------------------- blend across stage
   assign ab_diff = {b_ff[LERP_W-1], b_ff} - {a_ff[LERP_W-1], a_ff};
   assign fx_s    = $signed({1'b0, p2_fx_ff});
   assign t_prod  = ab_diff * fx_s;
   assign t_base  = {{2{a_ff[LERP_W-1]}}, a_ff, {FRAC_BITS{1'b0}}};
   assign t_full  = t_base + t_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_blend_ff <= p2_blend_ff;
      t_ff        <= t_full[T_W-1:0];
      p3_value_ff <= p2_value_ff;
   end

   // Negative sums are biased before the shift so the quotient truncates
   // toward zero.
   assign t_round = t_ff + (t_ff[T_W-1] ? ROUND_BIAS : '0);
   assign result  = p3_blend_ff ? t_round[T_W-1 -: HEIGHT_W] : p3_value_ff;

   hbs_queue #(
      .WIDTH (HEIGHT_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (p3_valid_ff),
      .push_ready (),
      .push_data  (result),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

endmodule

// ----- hdl/heightmap_bilinear_sampler.sv -----
// Heightmap bilinear sampler: keeps a 65536-entry map of signed 8-bit cell heights that
// write transactions load, and answers query transactions with an interpolated height.
// A write (req_tuser low) stores one cell and yields no result. A query (req_tuser high)
// carries an unsigned fixed-point position with FRAC_BITS fraction bits and yields exactly
// one result, in order: 0 when the cell lies outside the map, the cell's own height when
// both fractions are zero, 0 when the right or lower neighbour lies past the edge, and
// otherwise the four surrounding heights blended down the rows and then across, truncated
// toward zero. A query that blends four cells makes one read for each of them on the single
// port of the height memory, and the back end takes no new item until its last read is
// issued. A result passes the front-end register, the command queue, the memory read
// register, the row-blend and column-blend registers and the result buffer before it is
// offered.
// The height memory is not cleared at reset: a cell must be written before it is read.
// The user must write map width and height over the csr port only while the block is idle; it is not enforced.
// Depends on hbs_pkg, hbs_front, hbs_queue and hbs_back.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, from bit 0 up: cell_index[15:0], cell_height[23:16], pos_x[39:24],
   // pos_y[55:40]
   input  logic [hbs_pkg::REQ_DATA_W-1:0]       req_tdata,
   // tuser: cmd (0 writes a cell, 1 queries a position)
   input  logic                                 req_tuser,
   // Response stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, from bit 0 up: sampled_height[7:0]
   output logic [hbs_pkg::HEIGHT_W-1:0]         rsp_tdata,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hbs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hbs_pkg::DIM_W-1:0]            csr_data
);

   localparam int ADDR_W   = hbs_pkg::ADDR_W;
   localparam int HEIGHT_W = hbs_pkg::HEIGHT_W;
   localparam int POS_W    = hbs_pkg::POS_W;
   localparam int DIM_W    = hbs_pkg::DIM_W;
   localparam int ENTRY_W  = $bits(hbs_pkg::entry_type);
   localparam int CMDQ_W   = ENTRY_W + 2 * FRAC_BITS;
   localparam int CMDQ_DEPTH = 4;

   // Field positions within req_tdata.
   localparam int HEIGHT_LSB = ADDR_W;
   localparam int POS_X_LSB  = HEIGHT_LSB + HEIGHT_W;
   localparam int POS_Y_LSB  = POS_X_LSB + POS_W;

   logic [DIM_W-1:0]          map_width_ff;
   logic [DIM_W-1:0]          map_width_in;
   logic [DIM_W-1:0]          map_height_ff;
   logic [DIM_W-1:0]          map_height_in;
   logic                      csr_write;
   hbs_pkg::map_dims_type     dims;

   logic                      front_valid;
   logic                      front_ready;
   hbs_pkg::entry_type        front_entry;
   logic [FRAC_BITS-1:0]      front_fx;
   logic [FRAC_BITS-1:0]      front_fy;

   logic                      cmdq_valid;
   logic                      cmdq_ready;
   logic [CMDQ_W-1:0]         cmdq_data;
   hbs_pkg::entry_type        back_entry;

   // The configuration port never stalls; oversized values are clamped to the
   // largest map the design supports.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write) begin
         case (csr_index)
            hbs_pkg::CSR_MAP_WIDTH: begin
               map_width_in = (csr_data > hbs_pkg::MAX_WIDTH) ? hbs_pkg::MAX_WIDTH : csr_data;
            end
            hbs_pkg::CSR_MAP_HEIGHT: begin
               map_height_in = (csr_data > hbs_pkg::MAX_ROWS) ? hbs_pkg::MAX_ROWS : csr_data;
            end
            default: begin
               // Writes to other indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= hbs_pkg::DIM_RESET;
         map_height_ff <= hbs_pkg::DIM_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   assign dims.width  = map_width_ff;
   assign dims.height = map_height_ff;

   // The front end registers each transaction together with its classification
   // and the base cell address.
   hbs_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_cmd         (req_tuser),
      .in_cell_index  (req_tdata[ADDR_W-1:0]),
      .in_cell_height (req_tdata[POS_X_LSB-1:HEIGHT_LSB]),
      .in_pos_x       (req_tdata[POS_Y_LSB-1:POS_X_LSB]),
      .in_pos_y       (req_tdata[POS_Y_LSB+POS_W-1:POS_Y_LSB]),
      .dims           (dims),
      .out_valid      (front_valid),
      .out_ready      (front_ready),
      .out_entry      (front_entry),
      .out_fx         (front_fx),
      .out_fy         (front_fy)
   );

   // The command queue lets the front end keep accepting while the back end
   // makes the four reads of a blended query.
   hbs_queue #(
      .WIDTH (CMDQ_W),
      .DEPTH (CMDQ_DEPTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  ({front_fy, front_fx, front_entry}),
      .pop_valid  (cmdq_valid),
      .pop_ready  (cmdq_ready),
      .pop_data   (cmdq_data)
   );

   assign back_entry = hbs_pkg::entry_type'(cmdq_data[ENTRY_W-1:0]);

   // The back end owns the height memory, the interpolation pipeline and the
   // response buffer.
   hbs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (cmdq_valid),
      .entry_ready (cmdq_ready),
      .entry       (back_entry),
      .entry_fx    (cmdq_data[ENTRY_W+FRAC_BITS-1:ENTRY_W]),
      .entry_fy    (cmdq_data[CMDQ_W-1:ENTRY_W+FRAC_BITS]),
      .map_width   (map_width_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata)
   );

endmodule

// ----- hdl/hbs_checker.sv -----
// Port-level checks for the heightmap bilinear sampler, attached by a bind statement.
// Depends on hbs_pkg and on the port list of heightmap_bilinear_sampler.
`timescale 1ns / 1ps

module hbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [hbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hbs_pkg::HEIGHT_W-1:0]     rsp_tdata,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [hbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [hbs_pkg::DIM_W-1:0]        csr_data
);

   logic [7:0] pending_ff;
   logic [7:0] pending_in;
   logic       query_taken;
   logic       rsp_taken;

   assign query_taken = req_tvalid && req_tready && req_tuser;
   assign rsp_taken   = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({query_taken, rsp_taken})
         2'b10:   pending_in = pending_ff + 8'd1;
         2'b01:   pending_in = pending_ff - 8'd1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 8'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response belongs to a query that is still unanswered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 8'd0))
      else $error("response without an outstanding query");

   // With no query outstanding nothing may hold up the request stream.
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 8'd0) |-> req_tready)
      else $error("request stalled with no query outstanding");

   // A request that waits keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while stalled");

   // The configuration channel is always open and carries a defined payload.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown({csr_index, csr_data}))
      else $error("configuration write stalled or undefined");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for heightmap_bilinear_sampler: directed corner cases, register
// settings and back-pressure, then random cell writes and position queries under idling.
// Depends on hbs_pkg and the heightmap_bilinear_sampler RTL; needs nothing else.
`timescale 1ns / 1ps

module tb;

   localparam int POS_W       = hbs_pkg::POS_W;
   localparam int HEIGHT_W    = hbs_pkg::HEIGHT_W;
   localparam int ADDR_W      = hbs_pkg::ADDR_W;
   localparam int DIM_W       = hbs_pkg::DIM_W;
   localparam int CSR_INDEX_W = hbs_pkg::CSR_INDEX_W;
   localparam int REQ_DATA_W  = hbs_pkg::REQ_DATA_W;
   localparam int STORE_DEPTH = hbs_pkg::STORE_DEPTH;

   localparam int FRAC           = 8;
   localparam int TIMEOUT_CYCLES = 900000;
   // Allow a comfortable margin for writes that may still be in flight when the last result
   // has arrived.
   localparam int DRAIN_CYCLES   = 20;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // An index past the register list; the block must ignore writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 4'd15;

   // Request payload, last field listed sits in the lowest bits.
   typedef struct packed {
      logic [POS_W-1:0]           pos_y;
      logic [POS_W-1:0]           pos_x;
      logic signed [HEIGHT_W-1:0] cell_height;
      logic [ADDR_W-1:0]          cell_index;
   } req_fields_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                    req_tuser   = CMD_WRITE;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [HEIGHT_W-1:0]     rsp_tdata;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [DIM_W-1:0]        csr_data    = '0;

   heightmap_bilinear_sampler #(
      .FRAC_BITS (FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // The testbench's own view of the block: the height store, which cells have been
   // loaded, the map dimensions in force and the heights still owed by the block.
   logic signed [HEIGHT_W-1:0] height_copy [0:STORE_DEPTH-1];
   bit                         cell_loaded [0:STORE_DEPTH-1];
   hbs_pkg::map_dims_type      dims_copy = '{width: hbs_pkg::DIM_RESET,
                                             height: hbs_pkg::DIM_RESET};
   logic signed [HEIGHT_W-1:0] pending_heights [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoff_order = 0;
   int holdoff_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run must not hang: give up well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side. A long hold-off, when one is ordered, takes precedence over the
   // random stalls of the current idling mode.
   always @(posedge clock) begin
      if (holdoff_order > 0) begin
         holdoff_left  = holdoff_order;
         holdoff_order = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // Outputs are looked at on the falling edge, where they are stable; a transaction
   // seen here completes at the following rising edge.
   always @(negedge clock) begin
      logic signed [HEIGHT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_heights.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      $signed(rsp_tdata)));
         end else begin
            want = pending_heights.pop_front();
            if (rsp_tdata !== want)
               report_mismatch($sformatf("sampled_height expected %0d, got %0d",
                                         want, $signed(rsp_tdata)));
         end
      end
   end

   function automatic int unsigned cell_addr(input int unsigned row, input int unsigned col);
      return (row * 32'(dims_copy.width) + col) & 32'(STORE_DEPTH - 1);
   endfunction

   // Decides what a query needs: nothing (the answer is zero), one cell, or four cells.
   function automatic hbs_pkg::kind_type classify_query(input logic [POS_W-1:0] px,
                                                        input logic [POS_W-1:0] py);
      int unsigned xi, yi, fx, fy, w, h;
      xi = 32'(px) >> FRAC;
      yi = 32'(py) >> FRAC;
      fx = 32'(px[FRAC-1:0]);
      fy = 32'(py[FRAC-1:0]);
      w  = 32'(dims_copy.width);
      h  = 32'(dims_copy.height);
      if (xi >= w || yi >= h)
         return hbs_pkg::KIND_ZERO;
      if (fx == 0 && fy == 0)
         return hbs_pkg::KIND_CELL;
      if (xi + 1 >= w || yi + 1 >= h)
         return hbs_pkg::KIND_ZERO;
      return hbs_pkg::KIND_BLEND;
   endfunction

   // Blends down the rows first, then across, in exact integer arithmetic; the signed
   // division truncates toward zero as the block must.
   function automatic logic signed [HEIGHT_W-1:0] predict_height(input logic [POS_W-1:0] px,
                                                                 input logic [POS_W-1:0] py);
      int unsigned       xi, yi;
      longint            fx, fy, span, h1, h2, h3, h4, a, b, t;
      hbs_pkg::kind_type kind;
      kind = classify_query(px, py);
      xi   = 32'(px) >> FRAC;
      yi   = 32'(py) >> FRAC;
      fx   = longint'(px[FRAC-1:0]);
      fy   = longint'(py[FRAC-1:0]);
      span = longint'(1) << FRAC;
      case (kind)
         hbs_pkg::KIND_CELL: begin
            return height_copy[cell_addr(yi, xi)];
         end
         hbs_pkg::KIND_BLEND: begin
            h1 = longint'(height_copy[cell_addr(yi, xi)]);
            h2 = longint'(height_copy[cell_addr(yi, xi + 1)]);
            h3 = longint'(height_copy[cell_addr(yi + 1, xi)]);
            h4 = longint'(height_copy[cell_addr(yi + 1, xi + 1)]);
            a  = h1 * (span - fy) + h3 * fy;
            b  = h2 * (span - fy) + h4 * fy;
            t  = a * (span - fx) + b * fx;
            t  = t / (span * span);
            return t[HEIGHT_W-1:0];
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // Writes one register. The valid stays up when another write follows at once, so
   // that it is never lowered and raised within the same time step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [DIM_W-1:0] value,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      if (index == hbs_pkg::CSR_MAP_WIDTH)
         dims_copy.width = (value > hbs_pkg::MAX_WIDTH) ? hbs_pkg::MAX_WIDTH : value;
      else if (index == hbs_pkg::CSR_MAP_HEIGHT)
         dims_copy.height = (value > hbs_pkg::MAX_ROWS) ? hbs_pkg::MAX_ROWS : value;
      @(posedge clock);
      if (last)
         csr_valid <= 1'b0;
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_reg(hbs_pkg::CSR_MAP_WIDTH, w, 1'b0);
      write_reg(hbs_pkg::CSR_MAP_HEIGHT, h, 1'b1);
   endtask

   // Offers one transaction, with random idle cycles in front of it, and updates the
   // model once the block has taken it. Returns just after the accepting edge.
   task automatic send_item(input logic cmd, input req_fields_type fields);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= fields;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      if (cmd == CMD_WRITE) begin
         height_copy[fields.cell_index] = fields.cell_height;
         cell_loaded[fields.cell_index] = 1'b1;
      end else begin
         pending_heights = {pending_heights, predict_height(fields.pos_x, fields.pos_y)};
      end
      items_sent++;
      @(posedge clock);
   endtask

   // Position fields of a write are don't-care, so they carry random bits.
   task automatic write_cell(input int unsigned addr, input logic signed [HEIGHT_W-1:0] height);
      req_fields_type fields;
      fields.cell_index  = ADDR_W'(addr);
      fields.cell_height = height;
      fields.pos_x       = POS_W'($urandom);
      fields.pos_y       = POS_W'($urandom);
      send_item(CMD_WRITE, fields);
   endtask

   task automatic load_if_missing(input int unsigned addr);
      if (!cell_loaded[addr])
         write_cell(addr, HEIGHT_W'($urandom));
   endtask

   // A query may only read cells that hold a written height, so any cell it is going
   // to read is loaded first with a random height.
   task automatic query_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      req_fields_type    fields;
      int unsigned       xi, yi;
      hbs_pkg::kind_type kind;
      kind = classify_query(px, py);
      xi   = 32'(px) >> FRAC;
      yi   = 32'(py) >> FRAC;
      if (kind == hbs_pkg::KIND_CELL || kind == hbs_pkg::KIND_BLEND)
         load_if_missing(cell_addr(yi, xi));
      if (kind == hbs_pkg::KIND_BLEND) begin
         load_if_missing(cell_addr(yi, xi + 1));
         load_if_missing(cell_addr(yi + 1, xi));
         load_if_missing(cell_addr(yi + 1, xi + 1));
      end
      fields.cell_index  = ADDR_W'($urandom);
      fields.cell_height = HEIGHT_W'($urandom);
      fields.pos_x       = px;
      fields.pos_y       = py;
      send_item(CMD_QUERY, fields);
   endtask

   // Stops offering, waits until every owed result has come back and then lets any
   // write still inside the block settle, so that registers may be written safely.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Whole part up to the map limit, often just inside the last column or row, with
   // a random fraction.
   function automatic logic [POS_W-1:0] pick_coord(input int unsigned limit);
      int unsigned whole;
      logic [7:0]  frac_part;
      if ($urandom_range(99) < 20 && limit > 0)
         whole = limit - 1;
      else
         whole = $urandom_range(limit);
      if (whole > 255)
         whole = 255;
      frac_part = 8'($urandom_range(255));
      return {whole[7:0], frac_part};
   endfunction

   // Corners of the arithmetic at the reset dimensions of 256 by 256: flat patches at
   // both height extremes, truncation of a small negative blend toward zero, the far
   // corner cell and the queries that fall off the right and lower edges.
   task automatic test_blend_extremes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_cell(cell_addr(0, 0), -8'sd128);
      write_cell(cell_addr(0, 1), -8'sd128);
      write_cell(cell_addr(1, 0), -8'sd128);
      write_cell(cell_addr(1, 1), -8'sd128);
      query_at(16'h00FF, 16'h00FF);
      write_cell(cell_addr(2, 2), 8'sd127);
      write_cell(cell_addr(2, 3), 8'sd127);
      write_cell(cell_addr(3, 2), 8'sd127);
      write_cell(cell_addr(3, 3), 8'sd127);
      query_at(16'h02FF, 16'h02FF);
      // A quarter below zero must come out as zero, not minus one.
      write_cell(cell_addr(4, 4), -8'sd1);
      write_cell(cell_addr(4, 5), 8'sd0);
      write_cell(cell_addr(5, 4), 8'sd0);
      write_cell(cell_addr(5, 5), 8'sd0);
      query_at(16'h0480, 16'h0480);
      query_at(16'h0480, 16'h0400);
      write_cell(cell_addr(255, 255), 8'sd127);
      query_at(16'hFF00, 16'hFF00);
      query_at(16'hFFFF, 16'hFFFF);
      query_at(16'hFFFF, 16'h0000);
      drain_block();
   endtask

   // Zero sizes, sizes above the maximum, an index past the register list and a map
   // one cell wide.
   task automatic test_map_registers();
      set_dims(9'd0, 9'd256);
      query_at(16'h0000, 16'h0000);
      drain_block();
      set_dims(9'd256, 9'd0);
      query_at(16'h0000, 16'h0000);
      drain_block();
      set_dims(9'd511, 9'd511);
      query_at(16'hFF00, 16'hFF00);
      drain_block();
      write_reg(CSR_UNUSED, 9'd1, 1'b1);
      query_at(16'h00FF, 16'h00FF);
      drain_block();
      set_dims(9'd1, 9'd2);
      query_at(16'h0000, 16'h0000);
      query_at(16'h0080, 16'h0000);
      query_at(16'h0000, 16'h0100);
      drain_block();
   endtask

   // The result side holds off for a long stretch while queries keep coming, so the
   // block has to fill up and push back on its input.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_dims(9'd8, 9'd8);
      holdoff_order = 300;
      repeat (40) query_at(pick_coord(8), pick_coord(8));
      drain_block();
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                      input int count);
      int unsigned      w_now, h_now, pick, shape;
      int               first_item;
      logic [POS_W-1:0] px, py;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      set_dims(w, h);
      w_now      = 32'(dims_copy.width);
      h_now      = 32'(dims_copy.height);
      first_item = items_sent;
      while (items_sent - first_item < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            if ($urandom_range(99) < 10) begin
               px = POS_W'($urandom);
               py = POS_W'($urandom);
            end else begin
               px    = pick_coord(w_now);
               py    = pick_coord(h_now);
               shape = $urandom_range(99);
               // Many queries land exactly on a cell or on one of its grid lines.
               if (shape < 25) begin
                  px[7:0] = '0;
                  py[7:0] = '0;
               end else if (shape < 40) begin
                  px[7:0] = '0;
               end else if (shape < 55) begin
                  py[7:0] = '0;
               end
            end
            query_at(px, py);
         end else if (pick < 88 && w_now > 0 && h_now > 0) begin
            write_cell(cell_addr($urandom_range(h_now - 1), $urandom_range(w_now - 1)),
                       HEIGHT_W'($urandom));
         end else begin
            write_cell($urandom_range(STORE_DEPTH - 1), HEIGHT_W'($urandom));
         end
      end
      drain_block();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_blend_extremes();
      test_map_registers();
      test_output_backpressure();
      // Sender idles lightly while the result side stalls heavily.
      test_random_traffic(8, 80, 9'd8, 9'd6, 285);
      test_random_traffic(8, 80, 9'd256, 9'd256, 285);
      // And the other way round.
      test_random_traffic(80, 8, 9'd1, 9'd256, 285);
      test_random_traffic(80, 8, 9'd37, 9'd2, 285);
      // Flat out on both sides, with sizes that get clamped.
      test_random_traffic(0, 0, 9'd300, 9'd3, 285);
      test_random_traffic(0, 0, 9'd3, 9'd511, 285);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
